// ===== rtl/core/ilbm_body_row_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// ilbm_body_row_decoder assertion macros
// Concurrent check helpers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ILBM_BODY_ROW_DECODER_MACROS_SVH
`define ILBM_BODY_ROW_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ILBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ILBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ILBM_ASSERT(lbl, prop, msg)
`define ILBM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/ilbm_brd_pkg.sv =====
// ----------------------------------------------------------------------------
// ilbm_brd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package ilbm_brd_pkg;
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_PLANES  = 8;
  localparam int unsigned GROUPS_MAX  = (MAX_WIDTH + 15) / 16;
  localparam int unsigned STORE_BYTES = GROUPS_MAX * 2 * MAX_PLANES;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned PL_W        = 3;

  localparam logic [3:0] CFG_WIDTH      = 4'd0;
  localparam logic [3:0] CFG_HEIGHT     = 4'd1;
  localparam logic [3:0] CFG_PLANES     = 4'd2;
  localparam logic [3:0] CFG_COMPRESSED = 4'd3;

  typedef struct packed {
    logic            take;
    logic            store;
    logic            set_ovr;
    logic            clr_acc;
    logic            rd_en;
    logic [PL_W-1:0] rd_plane;
    logic            acc_en;
    logic            row_adv;
  } cmd_t;

  typedef struct packed {
    logic        compressed;
    logic        full;
    logic [10:0] room;
    logic        emit;
    logic        done;
    logic [3:0]  planes;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/ilbm_brd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilbm_brd_ctrl
// ByteRun1 decode sequencer: run tracking, store loop, group gather steps.
// ----------------------------------------------------------------------------
`default_nettype none
module ilbm_brd_ctrl import ilbm_brd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] body_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);
  typedef enum logic [2:0] {S_IDLE, S_STORE, S_GATHER, S_GLAST, S_OUT, S_END} state_e;
  typedef enum logic [1:0] {PH_CTRL, PH_LIT, PH_REP} phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      run_q, run_d, cnt_q, cnt_d;
  logic [PL_W-1:0] pl_q, pl_d;
  logic [7:0]      rep_cnt;
  logic [7:0]      lit_cnt;

  assign lit_cnt = body_byte_i + 8'd1;
  assign rep_cnt = 8'(9'd257 - {1'b0, body_byte_i});

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    pl_d    = pl_q;
    cmd_o   = '0;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (!sts_i.done) begin
            if (!sts_i.compressed) begin
              phase_d = PH_CTRL;
              run_d   = '0;
              cnt_d   = 8'd1;
              state_d = S_STORE;
            end else if (phase_q == PH_LIT) begin
              run_d   = (run_q == 8'd0) ? 8'd0 : run_q - 8'd1;
              if (run_d == 8'd0) phase_d = PH_CTRL;
              cnt_d   = 8'd1;
              state_d = S_STORE;
            end else if (phase_q == PH_REP) begin
              cnt_d   = run_q;
              run_d   = '0;
              phase_d = PH_CTRL;
              state_d = (run_q == 8'd0) ? S_END : S_STORE;
            end else begin
              if (!body_byte_i[7]) begin
                run_d   = lit_cnt;
                phase_d = PH_LIT;
                cmd_o.set_ovr = ({3'd0, lit_cnt} > sts_i.room);
              end else if (body_byte_i != 8'h80) begin
                run_d   = rep_cnt;
                phase_d = PH_REP;
                cmd_o.set_ovr = ({3'd0, rep_cnt} > sts_i.room);
              end
              state_d = S_END;
            end
          end
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        cnt_d = cnt_q - 8'd1;
        if (sts_i.emit) begin
          cmd_o.clr_acc = 1'b1;
          pl_d    = '0;
          state_d = S_GATHER;
        end else if (cnt_q == 8'd1) begin
          state_d = S_END;
        end
      end
      S_GATHER: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_plane = pl_q;
        cmd_o.acc_en   = (pl_q != '0);
        if ({1'b0, pl_q} == sts_i.planes - 4'd1) state_d = S_GLAST;
        else pl_d = pl_q + 1'b1;
      end
      S_GLAST: begin
        cmd_o.acc_en = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = (cnt_q == 8'd0) ? S_END : S_STORE;
      end
      S_END: begin
        cmd_o.row_adv = (phase_q == PH_CTRL) && sts_i.full;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_CTRL;
      run_q   <= '0;
      cnt_q   <= '0;
      pl_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      pl_q    <= pl_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ilbm_brd_dpath.sv =====
// ----------------------------------------------------------------------------
// ilbm_brd_dpath
// Configuration, geometry, row store, fill and row counters, pixel gather.
// ----------------------------------------------------------------------------
`default_nettype none
module ilbm_brd_dpath import ilbm_brd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [7:0]  body_byte_i,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  output logic [63:0]      pixels_low_o,
  output logic [63:0]      pixels_high_o,
  output logic [5:0]       column_group_o,
  output logic [4:0]       valid_pixels_o,
  output logic [15:0]      row_number_o,
  output logic             last_in_row_o,
  output logic             last_of_image_o,
  output logic             run_overrun_o
);
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [3:0]  planes_q;
  logic        comp_q;
  logic [10:0] pos_q;
  logic [15:0] row_q;
  logic        ovr_q, done_q;
  logic [7:0]  byte_q;
  logic [6:0]  grp_q;
  logic [PL_W-1:0] rdpl_q;
  logic [7:0]  rdh_q, rdl_q;
  logic [15:0][7:0] pix_q;
  logic [7:0]  mem [STORE_BYTES];

  logic [10:0] w_eff;
  logic [15:0] h_eff;
  logic [3:0]  p_eff;
  logic [6:0]  groups;
  logic [7:0]  psize;
  logic [10:0] row_bytes, last_base, rd_base;
  logic        full, emit, last_row;
  logic [6:0]  grp_now;
  logic [10:0] rem;
  logic [4:0]  valid;

  always_comb begin
    w_eff = width_q;
    if (width_q == 11'd0) w_eff = 11'd1;
    else if (width_q > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    p_eff = planes_q;
    if (planes_q == 4'd0) p_eff = 4'd1;
    else if (planes_q > 4'(MAX_PLANES)) p_eff = 4'(MAX_PLANES);
    h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  assign groups    = 7'(({1'b0, w_eff} + 12'd15) >> 4);
  assign psize     = {groups, 1'b0};
  assign row_bytes = 11'(psize * p_eff);
  assign last_base = 11'(psize * (p_eff - 4'd1));
  assign full      = pos_q >= row_bytes;
  assign emit      = !full && (pos_q >= last_base) && pos_q[0];
  assign grp_now   = 7'((pos_q - last_base) >> 1);
  assign last_row  = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
  assign rd_base   = 11'(psize * cmd_i.rd_plane) + {3'd0, grp_q, 1'b0};

  always_comb begin
    sts_o.compressed = comp_q;
    sts_o.full       = full;
    sts_o.room       = full ? 11'd0 : row_bytes - pos_q;
    sts_o.emit       = emit;
    sts_o.done       = done_q;
    sts_o.planes     = p_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd320;
      height_q <= 16'd200;
      planes_q <= 4'd5;
      comp_q   <= 1'b1;
      pos_q    <= '0;
      row_q    <= '0;
      ovr_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WIDTH:      width_q  <= cfg_data_i[10:0];
          CFG_HEIGHT:     height_q <= cfg_data_i;
          CFG_PLANES:     planes_q <= cfg_data_i[3:0];
          CFG_COMPRESSED: comp_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.set_ovr) ovr_q <= 1'b1;
      if (cmd_i.store && !full) pos_q <= pos_q + 11'd1;
      if (cmd_i.row_adv) begin
        pos_q <= '0;
        if (last_row) done_q <= 1'b1;
        else row_q <= row_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) byte_q <= body_byte_i;
    if (cmd_i.store && !full) mem[pos_q[ADDR_W-1:0]] <= byte_q;
    if (cmd_i.store) grp_q <= grp_now;
    if (cmd_i.rd_en) begin
      rdh_q  <= mem[rd_base[ADDR_W-1:0]];
      rdl_q  <= mem[rd_base[ADDR_W-1:0] + 1'b1];
      rdpl_q <= cmd_i.rd_plane;
    end
    if (cmd_i.clr_acc) pix_q <= '0;
    else if (cmd_i.acc_en) begin
      for (int i = 0; i < 8; i++) begin
        pix_q[i][rdpl_q]     <= rdh_q[7-i];
        pix_q[i + 8][rdpl_q] <= rdl_q[7-i];
      end
    end
  end

  assign rem   = w_eff - {grp_q, 4'd0};
  assign valid = (rem > 11'd16) ? 5'd16 : rem[4:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pixels_low_o[8*i +: 8]  = (5'(i) < valid) ? pix_q[i] : 8'd0;
      pixels_high_o[8*i +: 8] = (5'(i + 8) < valid) ? pix_q[i + 8] : 8'd0;
    end
  end

  assign column_group_o  = grp_q[5:0];
  assign valid_pixels_o  = valid;
  assign row_number_o    = row_q;
  assign last_in_row_o   = (grp_q + 7'd1) == groups;
  assign last_of_image_o = last_in_row_o && last_row;
  assign run_overrun_o   = ovr_q;
endmodule
`default_nettype wire

// ===== rtl/core/ilbm_body_row_decoder.sv =====
// ----------------------------------------------------------------------------
// ilbm_body_row_decoder
// ILBM body decoder: ByteRun1 or raw bytes into a row store, planar groups
// gathered into 16 chunky 8-bit pixel indices per result.
// ----------------------------------------------------------------------------
// One body byte is accepted while the sequencer is idle. A control byte goes
// to S_END; a literal or raw byte to S_STORE, then S_END; a repeat byte stays
// in S_STORE for its n copies, one row store write per cycle unless a column
// group is being gathered or output. Each stored byte that completes a 16-pixel
// column group starts a gather (two row store reads per plane, then S_GLAST)
// and S_OUT, where the result waits to be taken. The configuration port is
// always ready. After the last row all bytes are taken and dropped until reset.
`default_nettype none
`include "ilbm_body_row_decoder_macros.svh"
module ilbm_body_row_decoder import ilbm_brd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  body_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      pixels_low_o,
  output logic [63:0]      pixels_high_o,
  output logic [5:0]       column_group_o,
  output logic [4:0]       valid_pixels_o,
  output logic [15:0]      row_number_o,
  output logic             last_in_row_o,
  output logic             last_of_image_o,
  output logic             run_overrun_o
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ilbm_brd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .body_byte_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  ilbm_brd_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .body_byte_i,
    .cmd_i(cmd), .sts_o(sts), .pixels_low_o, .pixels_high_o, .column_group_o,
    .valid_pixels_o, .row_number_o, .last_in_row_o, .last_of_image_o,
    .run_overrun_o
  );

  `ILBM_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input taken during output")
  `ILBM_ASSERT(a_valid_range, out_valid_o |-> (valid_pixels_o - 5'd1) < 5'd16, "bad valid_pixels")
  `ILBM_ASSERT(a_last_img, out_valid_o && last_of_image_o |-> last_in_row_o, "last_of_image alone")
endmodule
`default_nettype wire
